// ===== hdl/histogram_bucket_counter_unit_defines.svh =====
// assertion macros used by the checker
`ifndef HISTOGRAM_BUCKET_COUNTER_UNIT_DEFINES_SVH
`define HISTOGRAM_BUCKET_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define HBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hbc check failed");

// next-cycle implication
`define HBC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hbc check failed");

// implication after a fixed number of cycles
`define HBC_ASSERT_DLY(label, ante, n, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("hbc check failed");

`endif

// ===== hdl/hbc_pkg.sv =====
`default_nettype none

package hbc_pkg;

  // field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned SCALE_W     = 24;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned PROD_W      = SAMPLE_W + SCALE_W;
  localparam int unsigned BUCKET_W    = PROD_W - FRAC_W;
  localparam int unsigned LIMIT_W     = 7;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned OUT_COUNT_W = 24;
  localparam int unsigned TOTAL_W     = 31;
  localparam int unsigned SUMSQ_W     = 56;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_SCALE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS_IN_USE = 2'd2;

  // reset values of the configuration registers
  localparam logic [SAMPLE_W-1:0] RANGE_LOW_RESET = 16'd0;
  localparam logic [SCALE_W-1:0]  SCALE_RESET     = 24'd32768;
  localparam logic [LIMIT_W-1:0]  BUCKETS_RESET   = 7'd50;

  // command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // sequencer step enables
  typedef struct packed {
    logic capture;
    logic multiply;
    logic lookup;
    logic update;
  } hbc_step_t;

  // classification of the item in flight
  typedef struct packed {
    logic               is_read;
    logic               in_range;
    logic               idx_ok;
    logic [INDEX_W-1:0] index;
  } hbc_lookup_t;

endpackage

`default_nettype wire

// ===== hdl/hbc_classify.sv =====
`default_nettype none

module hbc_classify #(
  parameter int unsigned BUCKET_SLOTS = 64,
  parameter int unsigned AW           = 6
) (
  input  logic                           clk_i,
  input  hbc_pkg::hbc_step_t             step_i,
  input  logic                           command_i,
  input  logic [hbc_pkg::SAMPLE_W-1:0]   sample_value_i,
  input  logic [hbc_pkg::INDEX_W-1:0]    read_index_i,
  input  logic [hbc_pkg::SAMPLE_W-1:0]   range_low_i,
  input  logic [hbc_pkg::SCALE_W-1:0]    bucket_scale_i,
  input  logic [hbc_pkg::LIMIT_W-1:0]    buckets_in_use_i,
  output logic [AW-1:0]                  addr_o,
  output hbc_pkg::hbc_lookup_t           lookup_o
);
  import hbc_pkg::*;

  logic                cmd_q;
  logic [INDEX_W-1:0]  ridx_q;
  logic                below_q;
  logic [SAMPLE_W-1:0] diff_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic [PROD_W-1:0]   prod;
  logic [LIMIT_W-1:0]  limit;
  logic                add_hit;
  logic                rd_ok;
  logic                rd_in;
  logic                is_read;
  hbc_lookup_t         lookup_q;

  // capture the item and offset the sample
  always_ff @(posedge clk_i) begin
    if (step_i.capture) begin
      cmd_q   <= command_i;
      ridx_q  <= read_index_i;
      below_q <= sample_value_i < range_low_i;
      diff_q  <= sample_value_i - range_low_i;
    end
  end

  // bucket number is the integer part of the q16 product
  assign prod = PROD_W'(diff_q) * PROD_W'(bucket_scale_i);

  always_ff @(posedge clk_i) begin
    if (step_i.multiply) begin
      bucket_q <= prod[PROD_W-1:FRAC_W];
    end
  end

  // buckets in use, capped by the store size
  assign limit = (32'(buckets_in_use_i) < BUCKET_SLOTS) ? buckets_in_use_i
                                                        : LIMIT_W'(BUCKET_SLOTS);

  assign is_read = (cmd_q == CMD_READ);
  assign add_hit = !below_q && (bucket_q < BUCKET_W'(limit));
  assign rd_ok   = 32'(ridx_q) < BUCKET_SLOTS;
  assign rd_in   = LIMIT_W'(ridx_q) < limit;

  // memory address, held stable through read and write-back
  assign addr_o = is_read ? AW'(ridx_q) : AW'(bucket_q);

  // register the classification next to the memory read
  always_ff @(posedge clk_i) begin
    if (step_i.lookup) begin
      lookup_q.is_read  <= is_read;
      lookup_q.in_range <= is_read ? rd_in : add_hit;
      lookup_q.idx_ok   <= is_read ? rd_ok : add_hit;
      if (is_read) begin
        lookup_q.index <= ridx_q;
      end else if (add_hit) begin
        lookup_q.index <= INDEX_W'(bucket_q);
      end else begin
        lookup_q.index <= '0;
      end
    end
  end

  assign lookup_o = lookup_q;

endmodule

`default_nettype wire

// ===== hdl/hbc_count_mem.sv =====
`default_nettype none

module hbc_count_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6,
  parameter int unsigned CW    = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [CW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [CW-1:0] wr_data_i
);

  logic [CW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [CW-1:0]    rd_data_q;
  logic             rd_valid_q;

  // count storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= (32'(rd_addr_i) < DEPTH) && valid_q[rd_addr_i];
      end
    end
  end

  // an unwritten entry reads as zero
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

// ===== hdl/hbc_update.sv =====
`default_nettype none

module hbc_update #(
  parameter int unsigned CW = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hbc_pkg::hbc_step_t               step_i,
  input  hbc_pkg::hbc_lookup_t             lookup_i,
  input  logic [CW-1:0]                    count_i,
  output logic                             wr_en_o,
  output logic [CW-1:0]                    wr_data_o,
  output logic [hbc_pkg::INDEX_W-1:0]      bucket_index_o,
  output logic                             in_range_o,
  output logic [hbc_pkg::OUT_COUNT_W-1:0]  bucket_count_o,
  output logic [hbc_pkg::TOTAL_W-1:0]      total_count_o,
  output logic [hbc_pkg::SUMSQ_W-1:0]      sum_squares_o
);
  import hbc_pkg::*;

  logic                 sat;
  logic [CW-1:0]        new_count;
  logic                 add_ok;
  logic                 bump;
  logic [CW:0]          inc;
  logic [SUMSQ_W:0]     sum_ext;
  logic [TOTAL_W-1:0]   total_d, total_q;
  logic [SUMSQ_W-1:0]   sumsq_d, sumsq_q;
  logic [CW-1:0]        report;
  logic [INDEX_W-1:0]   index_q;
  logic                 in_range_q;
  logic [OUT_COUNT_W-1:0] count_q;

  // saturating bucket increment
  assign sat       = &count_i;
  assign new_count = sat ? count_i : count_i + 1'b1;
  assign add_ok    = !lookup_i.is_read && lookup_i.in_range;
  assign bump      = step_i.update && add_ok && !sat;

  assign wr_en_o   = bump;
  assign wr_data_o = new_count;

  // totals: square sum grows by 2c+1, both saturate
  assign inc     = {count_i, 1'b1};
  assign sum_ext = {1'b0, sumsq_q} + (SUMSQ_W + 1)'(inc);
  assign sumsq_d = sum_ext[SUMSQ_W] ? '1 : sum_ext[SUMSQ_W-1:0];
  assign total_d = (&total_q) ? total_q : total_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      sumsq_q <= '0;
    end else if (bump) begin
      total_q <= total_d;
      sumsq_q <= sumsq_d;
    end
  end

  // result of the item
  always_comb begin
    if (!lookup_i.idx_ok) begin
      report = '0;
    end else if (lookup_i.is_read) begin
      report = count_i;
    end else begin
      report = new_count;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.update) begin
      index_q    <= lookup_i.index;
      in_range_q <= lookup_i.in_range;
      count_q    <= OUT_COUNT_W'(report);
    end
  end

  assign bucket_index_o = index_q;
  assign in_range_o     = in_range_q;
  assign bucket_count_o = count_q;
  assign total_count_o  = total_q;
  assign sum_squares_o  = sumsq_q;

endmodule

`default_nettype wire

// ===== hdl/histogram_bucket_counter_unit.sv =====
`default_nettype none

// Histogram engine. An item is accepted when start is high and busy is low; it is
// classified, its bucket counter is read from the count memory and, for an add command,
// incremented and written back, and the result appears on the result ports with strobe
// high for exactly one cycle. The receiver cannot stall: each result must be taken in
// that cycle. Busy is high through the multiply, memory read and write-back steps after
// acceptance, so a new item is not taken until the last one is through; the sequencer runs
// the capture, multiply, memory read and write-back steps one item at a time.
// Busy is low again in the strobe cycle, so the next item may be started then. Reset clears
// all counts and totals at once through per-entry valid flags; there is no clearing pass.
// Configuration writes take effect at once and should only be made while no item is in
// flight.
module histogram_bucket_counter_unit #(
  parameter int unsigned BUCKET_SLOTS = 64,
  parameter int unsigned COUNT_WIDTH  = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hbc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             start,
  output logic                             busy,
  input  logic                             command_i,
  input  logic [hbc_pkg::SAMPLE_W-1:0]     sample_value_i,
  input  logic [hbc_pkg::INDEX_W-1:0]      read_index_i,
  output logic                             strobe,
  output logic [hbc_pkg::INDEX_W-1:0]      bucket_index_o,
  output logic                             in_range_o,
  output logic [hbc_pkg::OUT_COUNT_W-1:0]  bucket_count_o,
  output logic [hbc_pkg::TOTAL_W-1:0]      total_count_o,
  output logic [hbc_pkg::SUMSQ_W-1:0]      sum_squares_o
);
  import hbc_pkg::*;

  // only buckets below the largest in-use count are ever reached
  localparam int unsigned DEPTH = (BUCKET_SLOTS < (2 ** LIMIT_W)) ? BUCKET_SLOTS
                                                                  : (2 ** LIMIT_W);
  localparam int unsigned AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_LOOK = 2'd2;
  localparam logic [1:0] ST_UPD  = 2'd3;

  logic [1:0]             state_d, state_q;
  logic                   strobe_q;
  logic [SAMPLE_W-1:0]    range_low_q;
  logic [SCALE_W-1:0]     bucket_scale_q;
  logic [LIMIT_W-1:0]     buckets_in_use_q;
  hbc_step_t              step;
  hbc_lookup_t            lookup;
  logic [AW-1:0]          addr;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] wr_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q      <= RANGE_LOW_RESET;
      bucket_scale_q   <= SCALE_RESET;
      buckets_in_use_q <= BUCKETS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE_LOW:      range_low_q      <= cfg_wdata_i[SAMPLE_W-1:0];
        CFG_BUCKET_SCALE:   bucket_scale_q   <= cfg_wdata_i[SCALE_W-1:0];
        CFG_BUCKETS_IN_USE: buckets_in_use_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // item sequencer
  always_comb begin
    unique case (state_q)
      ST_IDLE: state_d = start ? ST_MUL : ST_IDLE;
      ST_MUL:  state_d = ST_LOOK;
      ST_LOOK: state_d = ST_UPD;
      ST_UPD:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= (state_q == ST_UPD);
    end
  end

  assign step.capture  = (state_q == ST_IDLE) && start;
  assign step.multiply = (state_q == ST_MUL);
  assign step.lookup   = (state_q == ST_LOOK);
  assign step.update   = (state_q == ST_UPD);

  assign busy   = (state_q != ST_IDLE);
  assign strobe = strobe_q;

  hbc_classify #(
    .BUCKET_SLOTS (BUCKET_SLOTS),
    .AW           (AW)
  ) u_classify (
    .clk_i            (clk_i),
    .step_i           (step),
    .command_i        (command_i),
    .sample_value_i   (sample_value_i),
    .read_index_i     (read_index_i),
    .range_low_i      (range_low_q),
    .bucket_scale_i   (bucket_scale_q),
    .buckets_in_use_i (buckets_in_use_q),
    .addr_o           (addr),
    .lookup_o         (lookup)
  );

  hbc_count_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (COUNT_WIDTH)
  ) u_count_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (step.lookup),
    .rd_addr_i (addr),
    .rd_data_o (rd_count),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr),
    .wr_data_i (wr_data)
  );

  hbc_update #(
    .CW (COUNT_WIDTH)
  ) u_update (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .lookup_i       (lookup),
    .count_i        (rd_count),
    .wr_en_o        (wr_en),
    .wr_data_o      (wr_data),
    .bucket_index_o (bucket_index_o),
    .in_range_o     (in_range_o),
    .bucket_count_o (bucket_count_o),
    .total_count_o  (total_count_o),
    .sum_squares_o  (sum_squares_o)
  );

endmodule

`default_nettype wire

// ===== hdl/hbc_checker.sv =====
`default_nettype none

`include "histogram_bucket_counter_unit_defines.svh"

module hbc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic                        strobe,
  input logic                        in_range_o,
  input logic [hbc_pkg::TOTAL_W-1:0] total_count_o,
  input logic [hbc_pkg::SUMSQ_W-1:0] sum_squares_o
);

  // an accepted item holds the block busy
  `HBC_ASSERT_NXT(a_accept_busy, start && !busy, busy)

  // the result cycle already takes a new item
  `HBC_ASSERT_IMP(a_strobe_idle, strobe, !busy)

  // every accepted item later gives its result with strobe high
  `HBC_ASSERT_DLY(a_latency, start && !busy, 4, strobe)

  // an out-of-range item leaves the totals alone
  `HBC_ASSERT_IMP(a_miss_keeps_totals, strobe && !in_range_o, total_count_o == $past(total_count_o) && sum_squares_o == $past(sum_squares_o))

  // the running total never falls
  `HBC_ASSERT_IMP(a_total_monotonic, 1'b1, total_count_o >= $past(total_count_o))

endmodule

bind histogram_bucket_counter_unit hbc_checker u_hbc_checker (.*);

`default_nettype wire
